FILE: rtl/core/assert_macros.svh
// assertion macros shared by the rtl files
// expects clk_i and rst_ni in the scope of the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/rvdec_pkg.sv
// types shared by the rv32im control decoder
// no dependencies
`default_nettype none

package rvdec_pkg;

  typedef enum logic [3:0] {
    ALU_ADD    = 4'd0,
    ALU_SUB    = 4'd1,
    ALU_AND    = 4'd2,
    ALU_OR     = 4'd3,
    ALU_XOR    = 4'd4,
    ALU_SLT    = 4'd5,
    ALU_SLTU   = 4'd6,
    ALU_SLL    = 4'd7,
    ALU_SRL    = 4'd8,
    ALU_SRA    = 4'd9,
    ALU_MUL    = 4'd10,
    ALU_MULH   = 4'd11,
    ALU_MULHSU = 4'd12,
    ALU_MULHU  = 4'd13
  } alu_op_e;

  typedef enum logic [1:0] {
    MEM_NONE  = 2'd0,
    MEM_LOAD  = 2'd1,
    MEM_STORE = 2'd2
  } mem_op_e;

  typedef enum logic [1:0] {
    FLOW_SEQ    = 2'd0,
    FLOW_BR_POL0 = 2'd1,
    FLOW_BR_POL1 = 2'd2,
    FLOW_JUMP   = 2'd3
  } flow_e;

  typedef struct packed {
    logic        illegal;
    alu_op_e     alu_op;
    mem_op_e     mem_op;
    flow_e       flow;
    logic        a_from_pc;
    logic        b_from_imm;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm;
  } ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/rvdec_decode.sv
// combinational instruction decode into a control word
// depends on rvdec_pkg
`default_nettype none

module rvdec_decode
  import rvdec_pkg::*;
(
  input  logic [31:0] instr_i,
  output ctrl_t       ctrl_o
);

  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;

  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_WORD = 3'd2;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_b, imm_u, imm_j;
  alu_op_e     reg_op, imm_op;
  alu_op_e     br_op;
  flow_e       br_flow;

  assign opc = instr_i[6:0];
  assign rd  = instr_i[11:7];
  assign f3  = instr_i[14:12];
  assign rs1 = instr_i[19:15];
  assign rs2 = instr_i[24:20];
  assign f7  = instr_i[31:25];

  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_u = {instr_i[31:12], 12'h000};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};

  // reg-reg group; bad funct7 gives add, but xor/or/and ignore it
  always_comb begin
    reg_op = ALU_ADD;
    unique case (f3)
      F3_ADD: begin
        if (f7 == F7_BASE)        reg_op = ALU_ADD;
        else if (f7 == F7_ALT)    reg_op = ALU_SUB;
        else if (f7 == F7_MULDIV) reg_op = ALU_MUL;
      end
      F3_SLL: begin
        if (f7 == F7_BASE)        reg_op = ALU_SLL;
        else if (f7 == F7_MULDIV) reg_op = ALU_MULH;
      end
      F3_SLT: begin
        if (f7 == F7_BASE)        reg_op = ALU_SLT;
        else if (f7 == F7_MULDIV) reg_op = ALU_MULHSU;
      end
      F3_SLTU: begin
        if (f7 == F7_BASE)        reg_op = ALU_SLTU;
        else if (f7 == F7_MULDIV) reg_op = ALU_MULHU;
      end
      // divu lands on add; div, rem, remu land here as logic ops
      F3_XOR: reg_op = ALU_XOR;
      F3_SR: begin
        if (f7 == F7_BASE)        reg_op = ALU_SRL;
        else if (f7 == F7_ALT)    reg_op = ALU_SRA;
      end
      F3_OR:  reg_op = ALU_OR;
      F3_AND: reg_op = ALU_AND;
      default: reg_op = ALU_ADD;
    endcase
  end

  // register-immediate group; bit 30 picks arithmetic right shift
  always_comb begin
    imm_op = ALU_ADD;
    unique case (f3)
      F3_ADD:  imm_op = ALU_ADD;
      F3_SLL:  imm_op = ALU_SLL;
      F3_SLT:  imm_op = ALU_SLT;
      F3_SLTU: imm_op = ALU_SLTU;
      F3_XOR:  imm_op = ALU_XOR;
      F3_SR:   imm_op = instr_i[30] ? ALU_SRA : ALU_SRL;
      F3_OR:   imm_op = ALU_OR;
      F3_AND:  imm_op = ALU_AND;
      default: imm_op = ALU_ADD;
    endcase
  end

  // branch compare op and taken polarity
  always_comb begin
    br_op   = ALU_ADD;
    br_flow = FLOW_BR_POL0;
    unique case (f3)
      F3_BEQ:  begin br_op = ALU_SUB;  br_flow = FLOW_BR_POL0; end
      F3_BNE:  begin br_op = ALU_SUB;  br_flow = FLOW_BR_POL1; end
      F3_BLT:  begin br_op = ALU_SLT;  br_flow = FLOW_BR_POL1; end
      F3_BGE:  begin br_op = ALU_SLT;  br_flow = FLOW_BR_POL0; end
      F3_BLTU: begin br_op = ALU_SLTU; br_flow = FLOW_BR_POL1; end
      F3_BGEU: begin br_op = ALU_SLTU; br_flow = FLOW_BR_POL0; end
      default: begin br_op = ALU_ADD;  br_flow = FLOW_BR_POL0; end
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    unique case (opc)
      OPC_REG: begin
        ctrl_o.rd     = rd;
        ctrl_o.rs1    = rs1;
        ctrl_o.rs2    = rs2;
        ctrl_o.alu_op = reg_op;
      end
      OPC_IMM: begin
        ctrl_o.rd         = rd;
        ctrl_o.rs1        = rs1;
        ctrl_o.imm        = imm_i;
        ctrl_o.b_from_imm = 1'b1;
        ctrl_o.alu_op     = imm_op;
      end
      OPC_LUI: begin
        ctrl_o.rd         = rd;
        ctrl_o.imm        = imm_u;
        ctrl_o.b_from_imm = 1'b1;
      end
      OPC_AUIPC: begin
        ctrl_o.rd         = rd;
        ctrl_o.imm        = imm_u;
        ctrl_o.a_from_pc  = 1'b1;
        ctrl_o.b_from_imm = 1'b1;
      end
      OPC_STORE: begin
        // a non-word store is quietly a no-op
        ctrl_o.rs1        = rs1;
        ctrl_o.rs2        = rs2;
        ctrl_o.imm        = imm_s;
        ctrl_o.b_from_imm = 1'b1;
        ctrl_o.mem_op     = (f3 == F3_WORD) ? MEM_STORE : MEM_NONE;
      end
      OPC_LOAD: begin
        ctrl_o.rd         = rd;
        ctrl_o.rs1        = rs1;
        ctrl_o.imm        = imm_i;
        ctrl_o.b_from_imm = 1'b1;
        ctrl_o.mem_op     = (f3 == F3_WORD) ? MEM_LOAD : MEM_NONE;
        ctrl_o.illegal    = (f3 != F3_WORD);
      end
      OPC_JAL: begin
        ctrl_o.rd         = rd;
        ctrl_o.imm        = imm_j;
        ctrl_o.a_from_pc  = 1'b1;
        ctrl_o.b_from_imm = 1'b1;
        ctrl_o.flow       = FLOW_JUMP;
      end
      OPC_JALR: begin
        ctrl_o.rd         = rd;
        ctrl_o.rs1        = rs1;
        ctrl_o.imm        = imm_i;
        ctrl_o.b_from_imm = 1'b1;
        ctrl_o.flow       = FLOW_JUMP;
      end
      OPC_BRANCH: begin
        ctrl_o.rs1    = rs1;
        ctrl_o.rs2    = rs2;
        ctrl_o.imm    = imm_b;
        ctrl_o.alu_op = br_op;
        ctrl_o.flow   = br_flow;
      end
      default: begin
        ctrl_o.illegal = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/rv32im_control_decoder.sv
// rv32im control decoder top: input register, decode, result register
// depends on rvdec_pkg, rvdec_decode and assert_macros.svh
//
//   channel | signals                                        | direction
//   in      | in_valid_i, in_ready_o, instruction_i          | to block
//   out     | out_valid_o, out_ready_i, illegal_o ... imm    | from block
//
// an instruction is registered twice before out_valid_o: one register
// holds the instruction, one holds the decoded control word.
// one instruction per cycle sustained while out_ready_i stays high; the decode
// sits between the two registers. ready runs back from out_ready_i through each
// stage, so a stall at the output holds both stages and fills them before
// in_ready_o drops. reset empties both stages; payload registers are not reset.
`default_nettype none
`include "assert_macros.svh"

module rv32im_control_decoder
  import rvdec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [31:0]        instruction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               illegal_o,
  output logic [3:0]         alu_operation_o,
  output logic [1:0]         memory_op_o,
  output logic [1:0]         flow_o,
  output logic               a_from_pc_o,
  output logic               b_from_imm_o,
  output logic [4:0]         dest_reg_o,
  output logic [4:0]         src1_reg_o,
  output logic [4:0]         src2_reg_o,
  output logic signed [31:0] immediate_o
);

  logic        instr_valid_q, instr_valid_d;
  logic [31:0] instr_q;
  logic        res_valid_q, res_valid_d;
  ctrl_t       ctrl_q;
  ctrl_t       ctrl_d;
  logic        res_adv;
  logic        instr_load;
  logic        res_load;

  rvdec_decode u_decode (
    .instr_i (instr_q),
    .ctrl_o  (ctrl_d)
  );

  assign res_adv    = !res_valid_q || out_ready_i;
  assign in_ready_o = !instr_valid_q || res_adv;
  assign instr_load = in_valid_i && in_ready_o;
  assign res_load   = instr_valid_q && res_adv;

  always_comb begin
    instr_valid_d = instr_valid_q;
    res_valid_d   = res_valid_q;
    if (in_ready_o) begin
      instr_valid_d = in_valid_i;
    end
    if (res_adv) begin
      res_valid_d = instr_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_valid_q <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      instr_valid_q <= instr_valid_d;
      res_valid_q   <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (instr_load) begin
      instr_q <= instruction_i;
    end
    if (res_load) begin
      ctrl_q <= ctrl_d;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign illegal_o       = ctrl_q.illegal;
  assign alu_operation_o = ctrl_q.alu_op;
  assign memory_op_o     = ctrl_q.mem_op;
  assign flow_o          = ctrl_q.flow;
  assign a_from_pc_o     = ctrl_q.a_from_pc;
  assign b_from_imm_o    = ctrl_q.b_from_imm;
  assign dest_reg_o      = ctrl_q.rd;
  assign src1_reg_o      = ctrl_q.rs1;
  assign src2_reg_o      = ctrl_q.rs2;
  assign immediate_o     = $signed(ctrl_q.imm);

  // a transaction taken in always occupies the instruction stage next cycle
  `ASSERT_CLK(a_in_fills, in_valid_i && in_ready_o |=> instr_valid_q, "accepted instruction lost")
  // a full instruction stage moves on whenever the result slot frees up
  `ASSERT_CLK(a_stage_moves, instr_valid_q && res_adv |=> res_valid_q, "decoded word not captured")
  // an illegal instruction never starts a memory access
  `ASSERT_CLK(a_ill_no_mem, out_valid_o && illegal_o |-> memory_op_o == MEM_NONE, "illegal with memory op")
  // jumps always take the immediate as operand b
  `ASSERT_CLK(a_jump_imm, out_valid_o && flow_o == FLOW_JUMP |-> b_from_imm_o, "jump without immediate")
  // both stages are empty on the edge after reset is seen low
  `ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o && !instr_valid_q, "stage valid in reset")

endmodule

`default_nettype wire
